// File: sv/mwnv_pkg.sv
// shared constants and types of the masked window normalized variance unit
package mwnv_pkg;

  // default depth of one column buffer
  localparam int DEF_MAX_ROWS = 1024;
  // largest number of columns
  localparam int COL_LIMIT = 1024;

  // field and datapath widths
  localparam int PIX_W  = 16;   // pixel sample
  localparam int MEMB_W = 17;   // membership value
  localparam int ENT_W  = 18;   // stored entry: pixel, fg bit, bg bit
  localparam int CFG_W  = 11;   // configuration data
  localparam int POS_W  = 10;   // output row and column
  localparam int CNT_W  = 4;    // class member count, up to nine
  localparam int SUM_W  = 20;   // signed class sum
  localparam int SQS_W  = 34;   // class sum of squares
  localparam int DEN_W  = 37;   // squared sum, divisor
  localparam int QUO_W  = 32;   // Q16.16 figure
  localparam int FRAC_W = 16;   // fraction bits of the figure
  localparam int NUM_W  = 56;   // dividend
  localparam int PRD_W  = NUM_W - FRAC_W;

  localparam int FG_BIT = 16;
  localparam int BG_BIT = 17;

  localparam logic [MEMB_W-1:0] HALF_MEMBERSHIP = MEMB_W'(32768);
  localparam logic [QUO_W-1:0]  SAT32           = '1;
  localparam logic [CFG_W-1:0]  DIM_RESET       = CFG_W'(256);

  // configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  // result of the shared divider
  typedef struct packed {
    logic             ovf;
    logic [QUO_W-1:0] quot;
  } div_res_t;

endpackage

// File: sv/mwnv_div.sv
// shared radix-2 restoring divider with saturation detect
module mwnv_div import mwnv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output div_res_t         res
);

  localparam int DCNT_W = $clog2(QUO_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DEN_W:0]    rem_r;
  logic [QUO_W-1:0]  lo_r;
  logic [QUO_W-1:0]  quo_r;
  logic              ovf_r;
  logic [DEN_W:0]    sh;
  logic              ge;

  // one quotient bit per cycle
  assign sh = {rem_r[DEN_W-1:0], lo_r[QUO_W-1]};
  assign ge = sh >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DCNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (DEN_W + 1)'(numer[NUM_W-1:QUO_W]);
      lo_r  <= numer[QUO_W-1:0];
      quo_r <= '0;
      ovf_r <= DEN_W'(numer[NUM_W-1:QUO_W]) >= den;
    end else if (busy_r) begin
      rem_r <= ge ? (sh - {1'b0, den}) : sh;
      lo_r  <= {lo_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = ovf_r ? SAT32 : quo_r;

endmodule

// File: sv/masked_window_normalized_variance_unit.sv
// top level: column store, window gather, class sums and figure sequencer
// Pixels arrive in column-major order; each accepted word that completes a 3x3 window
// (row and column both at least 2) yields one to four result words, for the window centre
// and its border copies, with the foreground and background figures n(nQ-S^2)/S^2 in Q16.16.
// A word that completes no window is accepted and then written to the column store. A word
// that completes a window passes through the accept cycle, the reads of six stored entries
// from the column store (one read port, one write port) and the write of one entry back,
// the accumulation of the class sums, and per class the figure steps, dominated by the
// 32-step shared radix-2 divider, skipped for a class with no members or a zero sum; then
// its result words are offered until taken. The input is stalled the whole time.
// Writing the rows or columns configuration register restarts the position at row 0, column 0.
module masked_window_normalized_variance_unit import mwnv_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PIX_W-1:0] in_pixel,
  input  logic [MEMB_W-1:0]       in_membership,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic [QUO_W-1:0]        out_fg_value,
  output logic [QUO_W-1:0]        out_bg_value,
  output logic                    out_fg_overflow,
  output logic                    out_bg_overflow,
  output logic                    out_last_of_item
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CW  = (RCW > CFG_W) ? RCW : CFG_W;
  localparam int AW  = RW + 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_READ   = 10'b0000000010,
    S_WRITE  = 10'b0000000100,
    S_ACC    = 10'b0000001000,
    S_MUL1   = 10'b0000010000,
    S_SUB    = 10'b0000100000,
    S_MUL2   = 10'b0001000000,
    S_DSTART = 10'b0010000000,
    S_DWAIT  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [RW-1:0]    row_r;
  logic [POS_W-1:0] col_r;
  logic [ENT_W-1:0] rec0_r, rec1_r;
  logic [ENT_W-1:0] win_r [9];
  logic [AW-1:0]    wr_addr_r;
  logic [ENT_W-1:0] wr_data_r;
  logic [RW-1:0]    rbase_r;
  logic             par_r;
  logic             has_win_r;
  logic [RW-1:0]    ci_r, rr_r;
  logic [POS_W-1:0] cj_r, cc_r;
  logic             rext_r, cext_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_fg_r, n_bg_r;
  logic signed [SUM_W-1:0] s_fg_r, s_bg_r;
  logic [SQS_W-1:0] q_fg_r, q_bg_r;
  logic [QUO_W-1:0] sq_r;
  logic [1:0]       sqf_r;
  logic             cls_r;
  logic [DEN_W-1:0] d_r, nq_r, t_r;
  logic [NUM_W-1:0] numer_r;
  logic [QUO_W-1:0] fg_val_r, bg_val_r;
  logic             fg_ovf_r, bg_ovf_r;
  logic [1:0]       oidx_r;
  logic [ENT_W-1:0] rdata_r;
  logic [ENT_W-1:0] mem [2**AW];

  // effective image size
  logic [CW-1:0]    rows_ext;
  logic [RCW-1:0]   rows_eff;
  logic [CFG_W-1:0] cols_eff;

  always_comb begin
    rows_ext = CW'(rows_cfg_r);
    if (rows_ext < CW'(3)) begin
      rows_eff = RCW'(3);
    end else if (rows_ext > CW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_ext);
    end
    if (cols_cfg_r < CFG_W'(3)) begin
      cols_eff = CFG_W'(3);
    end else if (cols_cfg_r > CFG_W'(COL_LIMIT)) begin
      cols_eff = CFG_W'(COL_LIMIT);
    end else begin
      cols_eff = cols_cfg_r;
    end
  end

  // handshakes
  logic in_acc, out_acc, out_last, div_done;
  div_res_t div_res;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_acc   = out_valid && !out_stall;
  assign out_last  = oidx_r == {cext_r, rext_r};

  // position bookkeeping for the accepted word
  logic [ENT_W-1:0] cur_ent;
  logic             has_win;
  logic [RW-1:0]    pr;
  logic [POS_W-1:0] pc_prev;
  logic             pc_par;
  logic [RW-1:0]    ci;
  logic [POS_W-1:0] cj;
  logic             row_lo, row_hi, col_lo, col_hi;
  logic             row_wrap, col_wrap;

  always_comb begin
    cur_ent = {in_membership < HALF_MEMBERSHIP, in_membership > HALF_MEMBERSHIP, in_pixel};
    has_win = (row_r >= RW'(2)) && (col_r >= POS_W'(2));
    pc_prev = (col_r == '0) ? POS_W'(cols_eff - CFG_W'(1)) : col_r - POS_W'(1);
    if (row_r >= RW'(2)) begin
      pr     = row_r - RW'(2);
      pc_par = col_r[0];
    end else begin
      pr     = RW'(rows_eff - RCW'(2) + RCW'(row_r));
      pc_par = pc_prev[0];
    end
    ci       = row_r - RW'(1);
    cj       = col_r - POS_W'(1);
    row_lo   = ci == RW'(1);
    row_hi   = ci == RW'(rows_eff - RCW'(2));
    col_lo   = cj == POS_W'(1);
    col_hi   = cj == POS_W'(cols_eff - CFG_W'(2));
    row_wrap = (RCW'(row_r) + RCW'(1)) >= rows_eff;
    col_wrap = (CFG_W'(col_r) + CFG_W'(1)) >= cols_eff;
  end

  // read address of the stored window entries
  logic [1:0]    rd_off;
  logic [AW-1:0] rd_addr;

  always_comb begin
    rd_off  = (cnt_r < CNT_W'(3)) ? cnt_r[1:0] : 2'(cnt_r - CNT_W'(3));
    rd_addr = {(cnt_r < CNT_W'(3)) ? par_r : ~par_r, rbase_r + RW'(rd_off)};
  end

  // column store
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      mem[wr_addr_r] <= wr_data_r;
    end
    rdata_r <= mem[rd_addr];
  end

  // class selection for the figure steps
  logic [CNT_W-1:0]        n_sel;
  logic signed [SUM_W-1:0] s_sel;
  logic [SQS_W-1:0]        q_sel;
  logic [SUM_W-1:0]        mag;
  logic signed [PIX_W-1:0] p_sel;
  logic [1:0]              f_sel;

  always_comb begin
    n_sel = cls_r ? n_bg_r : n_fg_r;
    s_sel = cls_r ? s_bg_r : s_fg_r;
    q_sel = cls_r ? q_bg_r : q_fg_r;
    mag   = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
    p_sel = (cnt_r < CNT_W'(9)) ? win_r[cnt_r][PIX_W-1:0] : '0;
    f_sel = (cnt_r < CNT_W'(9)) ? win_r[cnt_r][BG_BIT:FG_BIT] : 2'b00;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = has_win ? S_READ : S_WRITE;
      S_READ:   if (cnt_r == CNT_W'(6)) state_nxt = S_WRITE;
      S_WRITE:  state_nxt = has_win_r ? S_ACC : S_IDLE;
      S_ACC:    if (cnt_r == CNT_W'(9)) state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_SUB;
      S_SUB: begin
        if ((n_sel != '0) && (d_r != '0)) begin
          state_nxt = S_MUL2;
        end else begin
          state_nxt = cls_r ? S_OUT : S_MUL1;
        end
      end
      S_MUL2:   state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (div_done) state_nxt = cls_r ? S_OUT : S_MUL1;
      S_OUT:    if (out_acc && out_last) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rows_cfg_r <= DIM_RESET;
      cols_cfg_r <= DIM_RESET;
      row_r      <= '0;
      col_r      <= '0;
      cnt_r      <= '0;
      cls_r      <= 1'b0;
      oidx_r     <= '0;
    end else begin
      state_r <= state_nxt;
      // a write to the rows or columns register restarts the image position
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS: begin
            rows_cfg_r <= cfg_data;
            row_r      <= '0;
            col_r      <= '0;
          end
          REG_COLS: begin
            cols_cfg_r <= cfg_data;
            row_r      <= '0;
            col_r      <= '0;
          end
          default: ;
        endcase
      end else if (in_acc) begin
        if (row_wrap) begin
          row_r <= '0;
          col_r <= col_wrap ? '0 : col_r + POS_W'(1);
        end else begin
          row_r <= row_r + RW'(1);
        end
      end
      // step counter for reads and accumulation
      if ((state_r == S_READ) || (state_r == S_ACC)) begin
        cnt_r <= (state_nxt == state_r) ? cnt_r + CNT_W'(1) : '0;
      end else begin
        cnt_r <= '0;
      end
      // class and result index
      if (state_r == S_ACC) begin
        cls_r <= 1'b0;
      end else if ((state_nxt == S_MUL1) && (state_r != S_MUL1)) begin
        cls_r <= 1'b1;
      end
      if (state_nxt == S_OUT && state_r != S_OUT) begin
        oidx_r <= '0;
      end else if (out_acc && !out_last) begin
        oidx_r <= oidx_r + (rext_r ? 2'd1 : 2'd2);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // capture of the accepted word
    if (in_acc) begin
      win_r[6]  <= rec1_r;
      win_r[7]  <= rec0_r;
      win_r[8]  <= cur_ent;
      wr_data_r <= rec1_r;
      wr_addr_r <= {pc_par, pr};
      rec1_r    <= rec0_r;
      rec0_r    <= cur_ent;
      has_win_r <= has_win;
      rbase_r   <= row_r - RW'(2);
      par_r     <= col_r[0];
      ci_r      <= ci;
      cj_r      <= cj;
      rext_r    <= row_lo || row_hi;
      cext_r    <= col_lo || col_hi;
      rr_r      <= row_lo ? '0 : RW'(rows_eff - RCW'(1));
      cc_r      <= col_lo ? '0 : POS_W'(cols_eff - CFG_W'(1));
      n_fg_r    <= '0;
      n_bg_r    <= '0;
      s_fg_r    <= '0;
      s_bg_r    <= '0;
      q_fg_r    <= '0;
      q_bg_r    <= '0;
    end
    // stored entries arrive in the cycle after their address
    if ((state_r == S_READ) && (cnt_r != '0)) begin
      win_r[cnt_r - CNT_W'(1)] <= rdata_r;
    end
    // square, count and sum one window entry per cycle
    if (state_r == S_ACC) begin
      sq_r  <= QUO_W'(QUO_W'(p_sel) * QUO_W'(p_sel));
      sqf_r <= f_sel;
      if (f_sel[0]) begin
        n_fg_r <= n_fg_r + CNT_W'(1);
        s_fg_r <= s_fg_r + SUM_W'(p_sel);
      end
      if (f_sel[1]) begin
        n_bg_r <= n_bg_r + CNT_W'(1);
        s_bg_r <= s_bg_r + SUM_W'(p_sel);
      end
      if (cnt_r != '0) begin
        if (sqf_r[0]) q_fg_r <= q_fg_r + SQS_W'(sq_r);
        if (sqf_r[1]) q_bg_r <= q_bg_r + SQS_W'(sq_r);
      end
    end
    // figure steps for the current class
    if (state_r == S_MUL1) begin
      d_r  <= DEN_W'(DEN_W'(mag) * DEN_W'(mag));
      nq_r <= DEN_W'(DEN_W'(n_sel) * DEN_W'(q_sel));
    end
    if (state_r == S_SUB) begin
      t_r <= nq_r - d_r;
      if (n_sel == '0) begin
        if (cls_r) begin
          bg_val_r <= '0;
          bg_ovf_r <= 1'b0;
        end else begin
          fg_val_r <= '0;
          fg_ovf_r <= 1'b0;
        end
      end else if (d_r == '0) begin
        if (cls_r) begin
          bg_val_r <= SAT32;
          bg_ovf_r <= 1'b1;
        end else begin
          fg_val_r <= SAT32;
          fg_ovf_r <= 1'b1;
        end
      end
    end
    if (state_r == S_MUL2) begin
      numer_r <= {PRD_W'(PRD_W'(n_sel) * PRD_W'(t_r)), FRAC_W'(0)};
    end
    if ((state_r == S_DWAIT) && div_done) begin
      if (cls_r) begin
        bg_val_r <= div_res.quot;
        bg_ovf_r <= div_res.ovf;
      end else begin
        fg_val_r <= div_res.quot;
        fg_ovf_r <= div_res.ovf;
      end
    end
  end

  // shared divider
  mwnv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DSTART),
    .numer (numer_r),
    .den   (d_r),
    .done  (div_done),
    .res   (div_res)
  );

  // result word
  assign out_row          = POS_W'(oidx_r[0] ? rr_r : ci_r);
  assign out_col          = oidx_r[1] ? cc_r : cj_r;
  assign out_fg_value     = fg_val_r;
  assign out_bg_value     = bg_val_r;
  assign out_fg_overflow  = fg_ovf_r;
  assign out_bg_overflow  = bg_ovf_r;
  assign out_last_of_item = out_last;

  // checks
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result word is pending");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT))
    else $error("divider finished outside its wait state");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_of_item) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after last result word");

endmodule
